FILE: sv/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, constants and lookup functions for the two-set composer.
// ----------------------------------------------------------------------------
package hts_pkg;

   localparam int HistDepthDefault = 8;

   localparam logic [4:0]  SlotEmpty   = 5'd31;
   localparam logic [15:0] SyllBase    = 16'hAC00;
   localparam logic [15:0] CompatVowel = 16'h314F;
   localparam logic [15:0] CompatInit0 = 16'h3131;
   localparam logic [7:0]  KeyFirst    = 8'h41;
   localparam logic [7:0]  KeyLast     = 8'h5A;
   localparam logic [4:0]  VowelCount  = 5'd21;
   localparam logic [4:0]  FinalCount  = 5'd28;
   localparam int          VPairs      = 7;
   localparam int          FPairs      = 11;

   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_BACK = 1'b1;

   // command from controller to datapath
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_KEY,      // evaluate one key in the key stage
      CMD_BS_START, // clear slots for a replay
      CMD_BS_STEP,  // replay one history entry
      CMD_BS_END,   // set history count after replay
      CMD_BS_CLEAR, // history already empty: clear slots
      CMD_OUTPUT    // latch the response
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       reject;  // output handled=0 response
   } ctl_type;

   typedef struct packed {
      logic       idle_comp;    // nothing composed
      logic       hist_empty;
      logic       replay_done;
   } sts_type;

   // key map: {kind[1:0], plain[4:0], shifted[4:0]}, kind 1 cons, 2 vowel
   function automatic logic [11:0] key_map(input logic [4:0] k);
      case (k)
         5'd0:  key_map = {2'd1, 5'd6,  5'd6 };
         5'd1:  key_map = {2'd2, 5'd17, 5'd17};
         5'd2:  key_map = {2'd1, 5'd14, 5'd14};
         5'd3:  key_map = {2'd1, 5'd11, 5'd11};
         5'd4:  key_map = {2'd1, 5'd3,  5'd4 };
         5'd5:  key_map = {2'd1, 5'd5,  5'd5 };
         5'd6:  key_map = {2'd1, 5'd18, 5'd18};
         5'd7:  key_map = {2'd2, 5'd8,  5'd8 };
         5'd8:  key_map = {2'd2, 5'd2,  5'd2 };
         5'd9:  key_map = {2'd2, 5'd4,  5'd4 };
         5'd10: key_map = {2'd2, 5'd0,  5'd0 };
         5'd11: key_map = {2'd2, 5'd20, 5'd20};
         5'd12: key_map = {2'd2, 5'd18, 5'd18};
         5'd13: key_map = {2'd2, 5'd13, 5'd13};
         5'd14: key_map = {2'd2, 5'd1,  5'd3 };
         5'd15: key_map = {2'd2, 5'd5,  5'd7 };
         5'd16: key_map = {2'd1, 5'd7,  5'd8 };
         5'd17: key_map = {2'd1, 5'd0,  5'd1 };
         5'd18: key_map = {2'd1, 5'd2,  5'd2 };
         5'd19: key_map = {2'd1, 5'd9,  5'd10};
         5'd20: key_map = {2'd2, 5'd6,  5'd6 };
         5'd21: key_map = {2'd1, 5'd17, 5'd17};
         5'd22: key_map = {2'd1, 5'd12, 5'd13};
         5'd23: key_map = {2'd1, 5'd16, 5'd16};
         5'd24: key_map = {2'd2, 5'd12, 5'd12};
         5'd25: key_map = {2'd1, 5'd15, 5'd15};
         default: key_map = 12'd0;
      endcase
   endfunction

   function automatic logic [4:0] pair_vowel(input logic [4:0] a, input logic [4:0] b);
      case ({a, b})
         {5'd8, 5'd0}:   pair_vowel = 5'd9;
         {5'd8, 5'd1}:   pair_vowel = 5'd10;
         {5'd8, 5'd20}:  pair_vowel = 5'd11;
         {5'd13, 5'd4}:  pair_vowel = 5'd14;
         {5'd13, 5'd5}:  pair_vowel = 5'd15;
         {5'd13, 5'd20}: pair_vowel = 5'd16;
         {5'd18, 5'd20}: pair_vowel = 5'd19;
         default:        pair_vowel = SlotEmpty;
      endcase
   endfunction

   function automatic logic [4:0] pair_final(input logic [4:0] a, input logic [4:0] b);
      case ({a, b})
         {5'd1, 5'd19}:  pair_final = 5'd3;
         {5'd4, 5'd22}:  pair_final = 5'd5;
         {5'd4, 5'd27}:  pair_final = 5'd6;
         {5'd8, 5'd1}:   pair_final = 5'd9;
         {5'd8, 5'd16}:  pair_final = 5'd10;
         {5'd8, 5'd17}:  pair_final = 5'd11;
         {5'd8, 5'd19}:  pair_final = 5'd12;
         {5'd8, 5'd25}:  pair_final = 5'd13;
         {5'd8, 5'd26}:  pair_final = 5'd14;
         {5'd8, 5'd27}:  pair_final = 5'd15;
         {5'd17, 5'd19}: pair_final = 5'd18;
         default:        pair_final = 5'd0;
      endcase
   endfunction

   // compound final -> {head, tail}; plain final -> {0, final}
   function automatic logic [9:0] split_final(input logic [4:0] f);
      case (f)
         5'd3:    split_final = {5'd1, 5'd19};
         5'd5:    split_final = {5'd4, 5'd22};
         5'd6:    split_final = {5'd4, 5'd27};
         5'd9:    split_final = {5'd8, 5'd1};
         5'd10:   split_final = {5'd8, 5'd16};
         5'd11:   split_final = {5'd8, 5'd17};
         5'd12:   split_final = {5'd8, 5'd19};
         5'd13:   split_final = {5'd8, 5'd25};
         5'd14:   split_final = {5'd8, 5'd26};
         5'd15:   split_final = {5'd8, 5'd27};
         5'd18:   split_final = {5'd17, 5'd19};
         default: split_final = {5'd0, f};
      endcase
   endfunction

   function automatic logic [4:0] fin_of_init(input logic [4:0] l);
      case (l)
         5'd0: fin_of_init = 5'd1;   5'd1: fin_of_init = 5'd2;
         5'd2: fin_of_init = 5'd4;   5'd3: fin_of_init = 5'd7;
         5'd5: fin_of_init = 5'd8;   5'd6: fin_of_init = 5'd16;
         5'd7: fin_of_init = 5'd17;  5'd9: fin_of_init = 5'd19;
         5'd10: fin_of_init = 5'd20; 5'd11: fin_of_init = 5'd21;
         5'd12: fin_of_init = 5'd22; 5'd14: fin_of_init = 5'd23;
         5'd15: fin_of_init = 5'd24; 5'd16: fin_of_init = 5'd25;
         5'd17: fin_of_init = 5'd26; 5'd18: fin_of_init = 5'd27;
         default: fin_of_init = 5'd0;
      endcase
   endfunction

   function automatic logic [4:0] init_of_fin(input logic [4:0] t);
      case (t)
         5'd1: init_of_fin = 5'd0;   5'd2: init_of_fin = 5'd1;
         5'd4: init_of_fin = 5'd2;   5'd7: init_of_fin = 5'd3;
         5'd8: init_of_fin = 5'd5;   5'd16: init_of_fin = 5'd6;
         5'd17: init_of_fin = 5'd7;  5'd19: init_of_fin = 5'd9;
         5'd20: init_of_fin = 5'd10; 5'd21: init_of_fin = 5'd11;
         5'd22: init_of_fin = 5'd12; 5'd23: init_of_fin = 5'd14;
         5'd24: init_of_fin = 5'd15; 5'd25: init_of_fin = 5'd16;
         5'd26: init_of_fin = 5'd17; 5'd27: init_of_fin = 5'd18;
         default: init_of_fin = SlotEmpty;
      endcase
   endfunction

   function automatic logic [15:0] compat_init(input logic [4:0] l);
      case (l)
         5'd0: compat_init = 16'h3131;  5'd1: compat_init = 16'h3132;
         5'd2: compat_init = 16'h3134;  5'd3: compat_init = 16'h3137;
         5'd4: compat_init = 16'h3138;  5'd5: compat_init = 16'h3139;
         5'd6: compat_init = 16'h3141;  5'd7: compat_init = 16'h3142;
         5'd8: compat_init = 16'h3143;  5'd9: compat_init = 16'h3145;
         5'd10: compat_init = 16'h3146; 5'd11: compat_init = 16'h3147;
         5'd12: compat_init = 16'h3148; 5'd13: compat_init = 16'h3149;
         5'd14: compat_init = 16'h314A; 5'd15: compat_init = 16'h314B;
         5'd16: compat_init = 16'h314C; 5'd17: compat_init = 16'h314D;
         5'd18: compat_init = 16'h314E;
         default: compat_init = CompatInit0;
      endcase
   endfunction

   function automatic logic [15:0] compat_vowel(input logic [4:0] v);
      compat_vowel = CompatVowel + ((v <= 5'd20) ? {11'd0, v} : 16'd0);
   endfunction

   // 0xAC00 + (l*21+v)*28 + t; small constant multiplies only
   function automatic logic [15:0] syllable(input logic [4:0] l, input logic [4:0] v,
                                            input logic [4:0] t);
      logic [9:0]  lv;
      logic [15:0] s;
      lv = 10'(l) * 10'(VowelCount) + 10'(v);
      s  = 16'(lv) * 16'(FinalCount);
      syllable = SyllBase + s + 16'(t);
   endfunction

endpackage

FILE: sv/hts_ctrl.sv
// ----------------------------------------------------------------------------
// hts_ctrl
// Request sequencer: key evaluation, backspace replay, response handoff.
// ----------------------------------------------------------------------------
module hts_ctrl
   import hts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_go,
   input  logic    req_type,
   input  logic    key_mapped,
   input  sts_type sts,
   input  logic    out_busy,
   output logic    req_take,
   output ctl_type ctl
);

   // commands are registered, so the datapath acts in the cycle after they are
   // issued; ST_BS_WAIT covers that lag and the registered history read
   typedef enum logic [1:0] {
      ST_IDLE, ST_BS_WAIT, ST_BS_RUN, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   ctl_type   ctl_ff, ctl_in;

   assign req_take = (state_ff == ST_IDLE) && req_go;
   assign ctl      = ctl_ff;

   always_comb begin
      state_in   = state_ff;
      ctl_in     = '{cmd: CMD_NONE, reject: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               if (req_type == REQ_KEY) begin
                  if (key_mapped) begin
                     ctl_in.cmd = CMD_KEY; state_in = ST_OUT;
                  end else begin
                     ctl_in.reject = 1'b1; state_in = ST_OUT;
                  end
               end else if (sts.idle_comp) begin
                  ctl_in.reject = 1'b1; state_in = ST_OUT;
               end else if (sts.hist_empty) begin
                  ctl_in.cmd = CMD_BS_CLEAR; state_in = ST_OUT;
               end else begin
                  ctl_in.cmd = CMD_BS_START; state_in = ST_BS_WAIT;
               end
            end
         end
         ST_BS_WAIT: begin
            state_in = ST_BS_RUN;
         end
         ST_BS_RUN: begin
            if (sts.replay_done) begin
               ctl_in.cmd = CMD_BS_END; state_in = ST_OUT;
            end else begin
               ctl_in.cmd = CMD_BS_STEP; state_in = ST_BS_WAIT;
            end
         end
         ST_OUT: begin
            if (!out_busy) begin
               ctl_in.cmd    = CMD_OUTPUT;
               ctl_in.reject = ctl_ff.reject;
               state_in      = ST_IDLE;
            end else begin
               ctl_in.reject = ctl_ff.reject;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctl_ff   <= '{cmd: CMD_NONE, reject: 1'b0};
      end else begin
         state_ff <= state_in;
         ctl_ff   <= ctl_in;
      end
   end

endmodule

FILE: sv/hts_dpath.sv
// ----------------------------------------------------------------------------
// hts_dpath
// Syllable slots, key history and response register.
// ----------------------------------------------------------------------------
module hts_dpath
   import hts_pkg::*;
#(
   parameter int HISTORY_DEPTH = HistDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_take,
   input  logic [7:0]  key_code,
   input  logic        shift_held,
   input  ctl_type     ctl,
   input  logic        rsp_stall,
   output logic        key_mapped,
   output sts_type     sts,
   output logic        out_busy,
   output logic        rsp_valid,
   output logic        rsp_handled,
   output logic        rsp_commit_valid,
   output logic [15:0] rsp_commit_code,
   output logic        rsp_preedit_valid,
   output logic [15:0] rsp_preedit_code
);

   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int IW = $clog2(HISTORY_DEPTH);

   logic [4:0]    init_ff, vow_ff, fin_ff;
   logic [CW-1:0] cnt_ff, cnt_in, ptr_ff, tgt_ff;
   logic [5:0]    hist_ff [HISTORY_DEPTH];
   logic [5:0]    rd_ff;
   logic          shift_ff;
   logic [7:0]    key_ff;
   logic          cv_ff;
   logic [15:0]   cc_ff;
   logic          valid_ff;
   logic          hnd_ff, ocv_ff, opv_ff;
   logic [15:0]   occ_ff, opc_ff;

   logic [11:0] km;
   logic [4:0]  jamo;
   logic        is_vow;
   logic [4:0]  ni, nv, nf;
   logic        ncv, push;
   logic [15:0] ncc;
   logic        rebuild;
   logic [5:0]  pe;
   logic [4:0]  nfi, cf, cv5;
   logic [9:0]  sp;
   logic [4:0]  ri, rv, rf, ri2;
   logic [5:0]  rh0, rh1;
   logic        rh1_en;
   logic [15:0] pc;
   logic        pvalid;

   assign key_mapped = (key_code >= KeyFirst) && (key_code <= KeyLast);
   assign km         = key_map(5'(key_ff - KeyFirst));
   assign jamo       = shift_ff ? km[4:0] : km[9:5];
   assign is_vow     = (km[11:10] == 2'd2);

   assign sts.idle_comp   = (init_ff == SlotEmpty) && (vow_ff == SlotEmpty) && (fin_ff == 5'd0);
   assign sts.hist_empty  = (cnt_ff == '0);
   assign sts.replay_done = (ptr_ff == tgt_ff);
   assign out_busy        = valid_ff && rsp_stall;

   // key evaluation
   always_comb begin
      ni = init_ff; nv = vow_ff; nf = fin_ff;
      ncv = 1'b0; ncc = 16'd0; push = 1'b0; rebuild = 1'b0; pe = 6'd0;
      nfi = fin_of_init(jamo);
      cf  = pair_final(fin_ff, nfi);
      cv5 = pair_vowel(vow_ff, jamo);
      sp  = split_final(fin_ff);
      if (!is_vow) begin
         if (init_ff == SlotEmpty && vow_ff == SlotEmpty) begin
            ni = jamo; nv = SlotEmpty; nf = 5'd0; rebuild = 1'b1;
         end else if (vow_ff == SlotEmpty) begin
            ncv = 1'b1; ncc = compat_init(init_ff);
            ni = jamo; nv = SlotEmpty; nf = 5'd0; rebuild = 1'b1;
         end else if (init_ff == SlotEmpty) begin
            ncv = 1'b1; ncc = compat_vowel(vow_ff);
            ni = jamo; nv = SlotEmpty; nf = 5'd0; rebuild = 1'b1;
         end else if (fin_ff == 5'd0 && nfi != 5'd0) begin
            nf = nfi; push = 1'b1; pe = {1'b0, jamo};
         end else if (fin_ff != 5'd0 && nfi != 5'd0 && cf != 5'd0) begin
            nf = cf; push = 1'b1; pe = {1'b0, jamo};
         end else begin
            ncv = 1'b1; ncc = syllable(init_ff, vow_ff, fin_ff);
            ni = jamo; nv = SlotEmpty; nf = 5'd0; rebuild = 1'b1;
         end
      end else begin
         if (init_ff == SlotEmpty && vow_ff == SlotEmpty) begin
            nv = jamo; nf = 5'd0; rebuild = 1'b1;
         end else if (vow_ff == SlotEmpty) begin
            nv = jamo; push = 1'b1; pe = {1'b1, jamo};
         end else if (fin_ff == 5'd0) begin
            if (cv5 != SlotEmpty) begin
               nv = cv5; push = 1'b1; pe = {1'b1, jamo};
            end else begin
               ncv = 1'b1;
               ncc = (init_ff == SlotEmpty) ? compat_vowel(vow_ff)
                                            : syllable(init_ff, vow_ff, 5'd0);
               ni = SlotEmpty; nv = jamo; nf = 5'd0; rebuild = 1'b1;
            end
         end else begin
            ncv = 1'b1; ncc = syllable(init_ff, vow_ff, sp[9:5]);
            ni = init_of_fin(sp[4:0]); nv = jamo; nf = 5'd0; rebuild = 1'b1;
         end
      end
      // rebuilt history: initial then vowel
      rh0    = (ni != SlotEmpty) ? {1'b0, ni} : {1'b1, nv};
      rh1    = {1'b1, nv};
      rh1_en = (ni != SlotEmpty) && (nv != SlotEmpty);
   end

   // replay of one history entry
   always_comb begin
      ri = init_ff; rv = vow_ff; rf = fin_ff;
      ri2 = fin_of_init(rd_ff[4:0]);
      if (!rd_ff[5]) begin
         if (init_ff == SlotEmpty) ri = rd_ff[4:0];
         else if (vow_ff != SlotEmpty && ri2 != 5'd0) begin
            if (fin_ff == 5'd0) rf = ri2;
            else if (pair_final(fin_ff, ri2) != 5'd0) rf = pair_final(fin_ff, ri2);
         end
      end else begin
         if (vow_ff == SlotEmpty) rv = rd_ff[4:0];
         else if (pair_vowel(vow_ff, rd_ff[4:0]) != SlotEmpty)
            rv = pair_vowel(vow_ff, rd_ff[4:0]);
      end
   end

   always_comb begin
      pvalid = 1'b1;
      if (init_ff != SlotEmpty && vow_ff != SlotEmpty) pc = syllable(init_ff, vow_ff, fin_ff);
      else if (init_ff != SlotEmpty) pc = compat_init(init_ff);
      else if (vow_ff != SlotEmpty) pc = compat_vowel(vow_ff);
      else begin
         pc = 16'd0; pvalid = 1'b0;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (rebuild) cnt_in = rh1_en ? CW'(2) : CW'(1);
      else if (push && cnt_ff < CW'(HISTORY_DEPTH)) cnt_in = cnt_ff + CW'(1);
   end

   // history memory
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_KEY) begin
         if (rebuild) begin
            hist_ff[0] <= rh0;
            if (rh1_en) hist_ff[1] <= rh1;
         end else if (push && cnt_ff < CW'(HISTORY_DEPTH)) begin
            hist_ff[cnt_ff[IW-1:0]] <= pe;
         end
      end
      rd_ff <= hist_ff[ptr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         key_ff <= key_code; shift_ff <= shift_held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= SlotEmpty; vow_ff <= SlotEmpty; fin_ff <= 5'd0;
         cnt_ff   <= '0; ptr_ff <= '0; tgt_ff <= '0;
         valid_ff <= 1'b0; cv_ff <= 1'b0; cc_ff <= 16'd0;
      end else begin
         if (ctl.cmd == CMD_OUTPUT) valid_ff <= 1'b1;
         else if (valid_ff && !rsp_stall) valid_ff <= 1'b0;
         case (ctl.cmd)
            CMD_KEY: begin
               init_ff <= ni; vow_ff <= nv; fin_ff <= nf;
               cnt_ff  <= cnt_in; cv_ff <= ncv; cc_ff <= ncc;
            end
            CMD_BS_CLEAR: begin
               init_ff <= SlotEmpty; vow_ff <= SlotEmpty; fin_ff <= 5'd0;
               cv_ff <= 1'b0; cc_ff <= 16'd0;
            end
            CMD_BS_START: begin
               init_ff <= SlotEmpty; vow_ff <= SlotEmpty; fin_ff <= 5'd0;
               cv_ff <= 1'b0; cc_ff <= 16'd0;
               tgt_ff <= cnt_ff - CW'(1);
               // pointer marks entries applied
               ptr_ff <= '0;
            end
            CMD_BS_STEP: begin
               init_ff <= ri; vow_ff <= rv; fin_ff <= rf;
               ptr_ff  <= ptr_ff + CW'(1);
            end
            CMD_BS_END: cnt_ff <= tgt_ff;
            default: ;
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_OUTPUT) begin
         hnd_ff <= !ctl.reject;
         ocv_ff <= !ctl.reject && cv_ff;
         occ_ff <= (!ctl.reject && cv_ff) ? cc_ff : 16'd0;
         opv_ff <= !ctl.reject && pvalid;
         opc_ff <= (!ctl.reject && pvalid) ? pc : 16'd0;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_handled       = hnd_ff;
   assign rsp_commit_valid  = ocv_ff;
   assign rsp_commit_code   = occ_ff;
   assign rsp_preedit_valid = opv_ff;
   assign rsp_preedit_code  = opc_ff;

endmodule

FILE: sv/hangul_two_set_composer.sv
// ----------------------------------------------------------------------------
// hangul_two_set_composer
// Two-set Korean keyboard composer: keys and backspace in, commit/preedit out.
// ----------------------------------------------------------------------------
// One request at a time. A key press, a rejected request or a backspace with
// an empty history raises rsp_valid once it is evaluated and its response
// latched. A backspace replays the remaining history, at most
// HISTORY_DEPTH - 1 entries, through the single registered history read port,
// each entry issued and then read. Requests that are rejected (unmapped key,
// backspace with nothing composed) still give one response with handled low.
// req_stall is high from acceptance until the response is latched; the next
// request may then be taken while that response still waits on rsp_stall.
module hangul_two_set_composer
   import hts_pkg::*;
#(
   parameter int HISTORY_DEPTH = HistDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_req_type,
   input  logic [7:0]  req_key_code,
   input  logic        req_shift_held,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_handled,
   output logic        rsp_commit_valid,
   output logic [15:0] rsp_commit_code,
   output logic        rsp_preedit_valid,
   output logic [15:0] rsp_preedit_code
);

   logic    req_take, key_mapped, out_busy, ready;
   ctl_type ctl;
   sts_type sts;
   logic    busy_ff;

   // stall while a request is in flight
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else if (req_take) busy_ff <= 1'b1;
      else if (ctl.cmd == CMD_OUTPUT) busy_ff <= 1'b0;
   end
   assign ready     = !busy_ff;
   assign req_stall = !ready;

   hts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_go     (req_valid && ready),
      .req_type   (req_req_type),
      .key_mapped (key_mapped),
      .sts        (sts),
      .out_busy   (out_busy),
      .req_take   (req_take),
      .ctl        (ctl)
   );

   hts_dpath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_take          (req_take),
      .key_code          (req_key_code),
      .shift_held        (req_shift_held),
      .ctl               (ctl),
      .rsp_stall         (rsp_stall),
      .key_mapped        (key_mapped),
      .sts               (sts),
      .out_busy          (out_busy),
      .rsp_valid         (rsp_valid),
      .rsp_handled       (rsp_handled),
      .rsp_commit_valid  (rsp_commit_valid),
      .rsp_commit_code   (rsp_commit_code),
      .rsp_preedit_valid (rsp_preedit_valid),
      .rsp_preedit_code  (rsp_preedit_code)
   );

   // a stalled response stays valid with its commit and preedit codes unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_commit_code)
                                 && $stable(rsp_preedit_code))
      else $error("stalled response changed");

   // a commit always comes with handled
   a_commit_handled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_commit_valid |-> rsp_handled)
      else $error("commit without handled");

   // a taken request stalls the input next cycle
   a_take_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after request");

endmodule

FILE: sim/hangul_two_set_composer_test.sv
// ----------------------------------------------------------------------------
// hangul_two_set_composer_test
// Self-checking bench: drives key and backspace requests, predicts each
// response with a behavioural composer and compares every field.
// ----------------------------------------------------------------------------
module hangul_two_set_composer_test
   import hts_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HistDepth = HistDepthDefault;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic        handled;
      logic        commit_valid;
      logic [15:0] commit_code;
      logic        preedit_valid;
      logic [15:0] preedit_code;
   } answer_type;

   logic        clock, reset;
   logic        req_valid, req_stall, req_req_type, req_shift_held;
   logic [7:0]  req_key_code;
   logic        rsp_valid, rsp_stall, rsp_handled, rsp_commit_valid, rsp_preedit_valid;
   logic [15:0] rsp_commit_code, rsp_preedit_code;

   hangul_two_set_composer dut (.*);

   // composer state held by the bench
   logic [4:0] cur_init, cur_vowel, cur_final;
   logic [5:0] keyed[HistDepth];
   int         keyed_n;

   answer_type expected_q[$];
   int         mismatches;
   int         send_idle_pct, stall_pct;
   int         cycles;

   // layout tables
   logic [1:0] lay_kind[26] = '{1,2,1,1,1,1,1,2,2,2,2,2,2,2,2,2,1,1,1,1,2,1,1,1,2,1};
   logic [4:0] lay_plain[26] = '{6,17,14,11,3,5,18,8,2,4,0,20,18,13,1,5,7,0,2,9,6,17,12,16,12,15};
   logic [4:0] lay_shift[26] = '{6,17,14,11,4,5,18,8,2,4,0,20,18,13,3,7,8,1,2,10,6,17,13,16,12,15};
   logic [4:0] vp_a[7] = '{8,8,8,13,13,13,18};
   logic [4:0] vp_b[7] = '{0,1,20,4,5,20,20};
   logic [4:0] vp_r[7] = '{9,10,11,14,15,16,19};
   logic [4:0] fp_a[11] = '{1,4,4,8,8,8,8,8,8,8,17};
   logic [4:0] fp_b[11] = '{19,22,27,1,16,17,19,25,26,27,19};
   logic [4:0] fp_r[11] = '{3,5,6,9,10,11,12,13,14,15,18};
   logic [4:0] i2f[19] = '{1,2,4,7,0,8,16,17,0,19,20,21,22,0,23,24,25,26,27};
   logic [4:0] f2i[28] = '{31,0,1,31,2,31,31,3,5,31,31,31,31,31,31,31,6,7,31,
                           9,10,11,12,14,15,16,17,18};
   logic [15:0] ci[19] = '{'h3131,'h3132,'h3134,'h3137,'h3138,'h3139,'h3141,'h3142,
                           'h3143,'h3145,'h3146,'h3147,'h3148,'h3149,'h314A,'h314B,
                           'h314C,'h314D,'h314E};

   function automatic logic [4:0] join_vowel(logic [4:0] a, logic [4:0] b);
      for (int i = 0; i < 7; i++)
         if (vp_a[i] == a && vp_b[i] == b) return vp_r[i];
      return SlotEmpty;
   endfunction

   function automatic logic [4:0] join_final(logic [4:0] a, logic [4:0] b);
      for (int i = 0; i < 11; i++)
         if (fp_a[i] == a && fp_b[i] == b) return fp_r[i];
      return 5'd0;
   endfunction

   function automatic logic [15:0] block_code(logic [4:0] l, logic [4:0] v, logic [4:0] t);
      int s;
      s = 'hAC00 + (l * 21 + v) * 28 + t;
      return s[15:0];
   endfunction

   function automatic logic [4:0] final_of(logic [4:0] l);
      return (l < 19) ? i2f[l] : 5'd0;
   endfunction

   function automatic logic [15:0] lone_init(logic [4:0] l);
      return (l < 19) ? ci[l] : 16'h3131;
   endfunction

   function automatic logic [15:0] lone_vowel(logic [4:0] v);
      return 16'(16'h314F + ((v <= 20) ? {11'd0, v} : 16'd0));
   endfunction

   function automatic void keep(logic [5:0] e);
      if (keyed_n < HistDepth) begin
         keyed[keyed_n] = e;
         keyed_n++;
      end
   endfunction

   function automatic void restart(logic [4:0] l, logic [4:0] v);
      cur_init = l; cur_vowel = v; cur_final = 0;
      keyed_n = 0;
      if (l != SlotEmpty) keep({1'b0, l});
      if (v != SlotEmpty) keep({1'b1, v});
   endfunction

   // advance the composer by one request and return the response
   function automatic answer_type compose(logic bs, logic [7:0] key, logic sh);
      answer_type a;
      logic [4:0] j, nf, c, head, tail, idx;
      int n;
      a = '0;
      if (bs == REQ_BACK) begin
         if (cur_init == SlotEmpty && cur_vowel == SlotEmpty && cur_final == 0) return a;
         if (keyed_n == 0) begin
            cur_init = SlotEmpty; cur_vowel = SlotEmpty; cur_final = 0;
         end else begin
            n = keyed_n - 1;
            cur_init = SlotEmpty; cur_vowel = SlotEmpty; cur_final = 0;
            for (int i = 0; i < n; i++) begin
               idx = keyed[i][4:0];
               if (!keyed[i][5]) begin
                  if (cur_init == SlotEmpty) cur_init = idx;
                  else if (cur_vowel != SlotEmpty) begin
                     nf = final_of(idx);
                     if (nf > 0) begin
                        if (cur_final == 0) cur_final = nf;
                        else begin
                           c = join_final(cur_final, nf);
                           if (c > 0) cur_final = c;
                        end
                     end
                  end
               end else if (cur_vowel == SlotEmpty) cur_vowel = idx;
               else begin
                  c = join_vowel(cur_vowel, idx);
                  if (c != SlotEmpty) cur_vowel = c;
               end
            end
            keyed_n = n;
         end
      end else begin
         if (key < KeyFirst || key > KeyLast) return a;
         j = sh ? lay_shift[key - KeyFirst] : lay_plain[key - KeyFirst];
         if (lay_kind[key - KeyFirst] == 1) begin
            nf = final_of(j);
            if (cur_init == SlotEmpty && cur_vowel == SlotEmpty) restart(j, SlotEmpty);
            else if (cur_vowel == SlotEmpty) begin
               a.commit_valid = 1; a.commit_code = lone_init(cur_init); restart(j, SlotEmpty);
            end else if (cur_init == SlotEmpty) begin
               a.commit_valid = 1; a.commit_code = lone_vowel(cur_vowel); restart(j, SlotEmpty);
            end else if (cur_final == 0 && nf > 0) begin
               cur_final = nf; keep({1'b0, j});
            end else if (cur_final == 0) begin
               a.commit_valid = 1; a.commit_code = block_code(cur_init, cur_vowel, 0);
               restart(j, SlotEmpty);
            end else begin
               c = (nf > 0) ? join_final(cur_final, nf) : 5'd0;
               if (c > 0) begin
                  cur_final = c; keep({1'b0, j});
               end else begin
                  a.commit_valid = 1;
                  a.commit_code = block_code(cur_init, cur_vowel, cur_final);
                  restart(j, SlotEmpty);
               end
            end
         end else begin
            if (cur_vowel == SlotEmpty && cur_init == SlotEmpty) restart(SlotEmpty, j);
            else if (cur_vowel == SlotEmpty) begin
               cur_vowel = j; keep({1'b1, j});
            end else if (cur_final == 0) begin
               c = join_vowel(cur_vowel, j);
               if (c != SlotEmpty) begin
                  cur_vowel = c; keep({1'b1, j});
               end else begin
                  a.commit_valid = 1;
                  a.commit_code = (cur_init == SlotEmpty) ? lone_vowel(cur_vowel)
                                  : block_code(cur_init, cur_vowel, 0);
                  restart(SlotEmpty, j);
               end
            end else begin
               // final (or compound tail) moves on to the next syllable
               head = 0; tail = cur_final;
               for (int i = 0; i < 11; i++)
                  if (fp_r[i] == cur_final) begin
                     head = fp_a[i]; tail = fp_b[i]; break;
                  end
               a.commit_valid = 1; a.commit_code = block_code(cur_init, cur_vowel, head);
               restart((tail < 28) ? f2i[tail] : SlotEmpty, j);
            end
         end
      end
      if (cur_init != SlotEmpty && cur_vowel != SlotEmpty) begin
         a.preedit_valid = 1; a.preedit_code = block_code(cur_init, cur_vowel, cur_final);
      end else if (cur_init != SlotEmpty) begin
         a.preedit_valid = 1; a.preedit_code = lone_init(cur_init);
      end else if (cur_vowel != SlotEmpty) begin
         a.preedit_valid = 1; a.preedit_code = lone_vowel(cur_vowel);
      end
      a.handled = 1;
      return a;
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // cycle counter and timeout guard
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver stall pattern, redrawn every cycle
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // response checker: oldest expectation against each accepted response
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_handled, rsp_commit_valid, rsp_commit_code,
                 rsp_preedit_valid, rsp_preedit_code};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   // send one request; prediction made when it is accepted. Valid stays high
   // between back-to-back requests and drops only for idle cycles or a drain.
   task automatic send(logic bs, logic [7:0] key, logic sh);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_req_type <= bs;
      req_key_code <= key;
      req_shift_held <= sh;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(compose(bs, key, sh));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // mostly letters, some backspaces, a few stray codes
   task automatic random_request();
      int r;
      r = $urandom_range(99);
      if (r < 70) send(REQ_KEY, 8'(KeyFirst + $urandom_range(25)), 1'($urandom));
      else if (r < 90) send(REQ_BACK, 8'($urandom), 1'($urandom));
      else send(REQ_KEY, 8'($urandom), 1'($urandom));
   endtask

   task automatic test_directed();
      // first eight letters, alternating plain and shifted, then extremes
      for (int k = 0; k < 8; k++) send(REQ_KEY, 8'(KeyFirst + k), k[0]);
      send(REQ_BACK, 8'h00, 1'b0);
      send(REQ_KEY, 8'h00, 1'b0);           // unmapped low
      send(REQ_KEY, 8'hFF, 1'b1);           // unmapped high
      send(REQ_KEY, 8'h40, 1'b0);
      send(REQ_KEY, 8'h5B, 1'b0);
      // dalg: compound final split on the following vowel
      send(REQ_KEY, "E", 0); send(REQ_KEY, "K", 0); send(REQ_KEY, "F", 0);
      send(REQ_KEY, "R", 0); send(REQ_KEY, "K", 0);
      // doubled consonant that cannot be a final
      send(REQ_KEY, "E", 1); send(REQ_KEY, "Q", 1);
      send(REQ_KEY, "H", 0); send(REQ_KEY, "K", 0); send(REQ_KEY, "R", 0); // vowel pair on the initial, then a final
      send(REQ_BACK, 0, 0); send(REQ_BACK, 0, 0); send(REQ_BACK, 0, 0);
      drain();
   endtask

   task automatic test_alphabet();
      for (int k = 0; k < 26; k++) begin
         send(REQ_KEY, 8'(KeyFirst + k), 1'b0);
         send(REQ_KEY, 8'(KeyFirst + k), 1'b1);
      end
      send(REQ_BACK, 0, 0);
      drain();
   endtask

   // long alternating runs, then a full backspace sweep
   task automatic test_history_full();
      for (int k = 0; k < 12; k++) send(REQ_KEY, (k % 2) ? "K" : "F", 1'b0);
      send(REQ_KEY, "R", 0); send(REQ_KEY, "F", 0); send(REQ_KEY, "G", 0);
      for (int k = 0; k < 12; k++) send(REQ_BACK, 8'($urandom), 1'($urandom));
      drain();
   endtask

   task automatic test_random_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) random_request();
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_req_type = REQ_KEY;
      req_key_code = 8'h00;
      req_shift_held = 1'b0;
      mismatches = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      restart(SlotEmpty, SlotEmpty);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_alphabet();
      test_history_full();
      test_random_phase(0, 0, 250);
      test_random_phase(53, 0, 250);
      test_random_phase(0, 53, 250);
      test_random_phase(24, 24, 200);
      drain();
      repeat (30) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
